// ===== src/upscl_pkg.sv =====
// ----------------------------------------------------------------------------
// Upscaler package
// Shared constants, codes and types of the pixel-replicating upscaler.
// ----------------------------------------------------------------------------
package upscl_pkg;

   localparam int MaxWidth     = 1024;
   localparam int ColBits      = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
   localparam int ScaleBits    = 7;
   localparam int WidthBits    = 11;
   localparam int HeightBits   = 13;
   localparam int ScaleLimit   = 100;
   localparam int HeightLimit  = 4096;
   localparam int RowBits      = $clog2(HeightLimit);
   localparam int ColCmpBits   = (ColBits + 1 > WidthBits) ? ColBits + 1 : WidthBits;
   localparam int WidthCapInt  = (MaxWidth < (1 << WidthBits)) ? MaxWidth
                                                               : (1 << WidthBits) - 1;
   localparam logic [WidthBits-1:0] WidthCap = WidthBits'(WidthCapInt);

   localparam int CsrIdxBits   = 2;
   localparam int CsrDataBits  = 13;

   localparam int QueueDepth   = 4;
   localparam int QueuePtrBits = $clog2(QueueDepth);

   typedef enum logic [CsrIdxBits-1:0] {
      CSR_SCALE  = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_TICK  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_PIXEL   = 2'd0,
      ST_IDLE    = 2'd1,
      ST_REFUSED = 2'd2
   } status_type;

   typedef struct packed {
      kind_type    kind;
      logic [23:0] rgb;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

endpackage

// ===== src/upscl_front.sv =====
// ----------------------------------------------------------------------------
// Upscaler front end
// Takes items from the request channel, sorts them into pixels and emit
// ticks, and hands them on to the queue.
// ----------------------------------------------------------------------------
module upscl_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,   // red, green, blue
   input  logic [0:0]          req_tuser,   // mode
   input  logic                push_ready,
   output logic                push_valid,
   output upscl_pkg::item_type push_item
);
   import upscl_pkg::*;

   logic     hold_valid_ff;
   logic     hold_valid_in;
   item_type item_ff;
   item_type item_in;
   logic     accept;

   assign req_tready = !hold_valid_ff || push_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      hold_valid_in = hold_valid_ff && !push_ready;
      item_in       = item_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         item_in.kind  = kind_type'(req_tuser[0]);
         item_in.rgb   = (req_tuser[0] == KIND_PIXEL) ? req_tdata : 24'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign push_valid = hold_valid_ff;
   assign push_item  = item_ff;

endmodule

// ===== src/upscl_queue.sv =====
// ----------------------------------------------------------------------------
// Upscaler item queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module upscl_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  upscl_pkg::item_type       push_item,
   output upscl_pkg::queue_head_type head,
   input  logic                      pop
);
   import upscl_pkg::*;

   item_type                entries [QueueDepth];
   logic [QueuePtrBits-1:0] wr_ptr_ff;
   logic [QueuePtrBits-1:0] wr_ptr_in;
   logic [QueuePtrBits-1:0] rd_ptr_ff;
   logic [QueuePtrBits-1:0] rd_ptr_in;
   logic [QueuePtrBits:0]   count_ff;
   logic [QueuePtrBits:0]   count_in;
   logic                    do_push;
   logic                    do_pop;

   assign push_ready = count_ff != (QueuePtrBits+1)'(QueueDepth);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head.valid;

   assign head.valid = count_ff != '0;
   assign head.item  = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QueueDepth - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QueueDepth - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/upscl_back.sv =====
// ----------------------------------------------------------------------------
// Upscaler back end
// Holds the settings, the line store and the row counters, carries out one
// queued item per cycle unless output stalls, and registers its result.
// ----------------------------------------------------------------------------
module upscl_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [upscl_pkg::CsrIdxBits-1:0]      csr_index,
   input  logic [upscl_pkg::CsrDataBits-1:0]     csr_data,
   input  upscl_pkg::queue_head_type             head,
   output logic                                  pop,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [31:0]                           rsp_tdata,  // red, green, blue, pad_bytes
   output logic [2:0]                            rsp_tuser,  // status, image_end
   output logic                                  rsp_tlast   // row_end
);
   import upscl_pkg::*;

   logic [ScaleBits-1:0]  scale_ff;
   logic [WidthBits-1:0]  width_ff;
   logic [HeightBits-1:0] height_ff;

   logic [ColBits-1:0]    load_col_ff,   load_col_in;
   logic                  replaying_ff,  replaying_in;
   logic [ColBits-1:0]    out_col_ff,    out_col_in;
   logic [ScaleBits-1:0]  copy_ff,       copy_in;
   logic [ScaleBits-1:0]  row_rep_ff,    row_rep_in;
   logic [RowBits-1:0]    src_row_ff,    src_row_in;

   logic                  out_valid_ff;
   status_type            status_ff,     status_in;
   logic [1:0]            pad_ff,        pad_in;
   logic                  rend_ff,       rend_in;
   logic                  iend_ff,       iend_in;
   logic [23:0]           rd_data_ff;

   logic [23:0]           line_store [MaxWidth];

   logic [ScaleBits-1:0]  s_eff;
   logic [WidthBits-1:0]  w_eff;
   logic [HeightBits-1:0] h_eff;
   logic                  advance;
   logic                  has_result;
   logic                  mem_we;
   logic                  mem_re;
   logic                  load_last;
   logic                  col_last;
   logic                  copy_last;
   logic                  rep_last;
   logic                  row_last;
   logic                  rend;
   logic [3:0]            pad_prod;

   assign csr_ready = 1'b1;

   always_comb begin
      if (scale_ff == '0) begin
         s_eff = ScaleBits'(1);
      end else if (32'(scale_ff) > ScaleLimit) begin
         s_eff = ScaleBits'(ScaleLimit);
      end else begin
         s_eff = scale_ff;
      end
      if (width_ff == '0) begin
         w_eff = WidthBits'(1);
      end else if (width_ff > WidthCap) begin
         w_eff = WidthCap;
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = HeightBits'(1);
      end else if (32'(height_ff) > HeightLimit) begin
         h_eff = HeightBits'(HeightLimit);
      end else begin
         h_eff = height_ff;
      end
   end

   // The pad count is minus three times the row length, modulo four.
   // Since three is minus one modulo four, it equals width times scale.
   assign pad_prod  = {2'b00, s_eff[1:0]} * {2'b00, w_eff[1:0]};

   assign load_last = (ColCmpBits'(load_col_ff) + ColCmpBits'(1)) >= ColCmpBits'(w_eff);
   assign col_last  = (ColCmpBits'(out_col_ff) + ColCmpBits'(1)) >= ColCmpBits'(w_eff);
   assign copy_last = ((ScaleBits+1)'(copy_ff) + (ScaleBits+1)'(1))
                      >= (ScaleBits+1)'(s_eff);
   assign rep_last  = ((ScaleBits+1)'(row_rep_ff) + (ScaleBits+1)'(1))
                      >= (ScaleBits+1)'(s_eff);
   assign row_last  = ((HeightBits+1)'(src_row_ff) + (HeightBits+1)'(1))
                      >= (HeightBits+1)'(h_eff);
   assign rend      = col_last && copy_last;

   assign advance = !out_valid_ff || rsp_tready;
   assign pop     = advance && head.valid;

   always_comb begin
      load_col_in  = load_col_ff;
      replaying_in = replaying_ff;
      out_col_in   = out_col_ff;
      copy_in      = copy_ff;
      row_rep_in   = row_rep_ff;
      src_row_in   = src_row_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      has_result   = 1'b0;
      status_in    = ST_IDLE;
      pad_in       = 2'd0;
      rend_in      = 1'b0;
      iend_in      = 1'b0;
      if (pop) begin
         if (head.item.kind == KIND_PIXEL) begin
            if (replaying_ff) begin
               has_result = 1'b1;
               status_in  = ST_REFUSED;
            end else begin
               mem_we = 1'b1;
               if (load_last) begin
                  load_col_in  = '0;
                  replaying_in = 1'b1;
                  out_col_in   = '0;
                  copy_in      = '0;
                  row_rep_in   = '0;
               end else begin
                  load_col_in = load_col_ff + 1'b1;
               end
            end
         end else if (!replaying_ff) begin
            has_result = 1'b1;
            status_in  = ST_IDLE;
         end else begin
            has_result = 1'b1;
            status_in  = ST_PIXEL;
            mem_re     = 1'b1;
            rend_in    = rend;
            iend_in    = rend && rep_last && row_last;
            pad_in     = rend ? pad_prod[1:0] : 2'd0;
            if (!copy_last) begin
               copy_in = copy_ff + 1'b1;
            end else begin
               copy_in = '0;
               if (!col_last) begin
                  out_col_in = out_col_ff + 1'b1;
               end else begin
                  out_col_in = '0;
                  if (!rep_last) begin
                     row_rep_in = row_rep_ff + 1'b1;
                  end else begin
                     row_rep_in   = '0;
                     replaying_in = 1'b0;
                     load_col_in  = '0;
                     src_row_in   = row_last ? '0 : src_row_ff + 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= ScaleBits'(1);
         width_ff     <= WidthBits'(1);
         height_ff    <= HeightBits'(1);
         load_col_ff  <= '0;
         replaying_ff <= 1'b0;
         out_col_ff   <= '0;
         copy_ff      <= '0;
         row_rep_ff   <= '0;
         src_row_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_SCALE:  scale_ff  <= csr_data[ScaleBits-1:0];
               CSR_WIDTH:  width_ff  <= csr_data[WidthBits-1:0];
               CSR_HEIGHT: height_ff <= csr_data[HeightBits-1:0];
               default:    scale_ff  <= scale_ff;
            endcase
         end
         load_col_ff  <= load_col_in;
         replaying_ff <= replaying_in;
         out_col_ff   <= out_col_in;
         copy_ff      <= copy_in;
         row_rep_ff   <= row_rep_in;
         src_row_ff   <= src_row_in;
         if (advance) begin
            out_valid_ff <= pop && has_result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= status_in;
         pad_ff    <= pad_in;
         rend_ff   <= rend_in;
         iend_ff   <= iend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_store[load_col_ff] <= head.item.rgb;
      end
      if (mem_re) begin
         rd_data_ff <= line_store[out_col_ff];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, pad_ff, (status_ff == ST_PIXEL) ? rd_data_ff : 24'd0};
   assign rsp_tuser  = {iend_ff, status_ff};
   assign rsp_tlast  = rend_ff;

`ifndef NO_ASSERTIONS
   a_load_counters_idle: assert property (@(posedge clock) disable iff (reset)
      replaying_ff |-> load_col_ff == '0)
      else $error("load column moved during replay");

   a_replay_counters_idle: assert property (@(posedge clock) disable iff (reset)
      !replaying_ff |-> (out_col_ff == '0 && copy_ff == '0 && row_rep_ff == '0))
      else $error("replay counters not cleared while loading");

   a_image_end_on_row_end: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && iend_ff) |-> (rend_ff && status_ff == ST_PIXEL))
      else $error("image end without row end");

   a_pad_only_at_row_end: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rend_ff) |-> pad_ff == 2'd0)
      else $error("pad bytes away from row end");
`endif

endmodule

// ===== src/pixel_replicating_upscaler.sv =====
// ----------------------------------------------------------------------------
// Pixel-replicating upscaler
// Enlarges a 24-bit image by an integer factor through pixel replication.
// ----------------------------------------------------------------------------
// Items enter on the req_ channel: tuser low offers a source pixel, tuser high
// is an emit tick asking for the next output pixel. Pixels of one source row
// fill the line store; the ticks that follow give the row out scale times,
// each pixel repeated scale times. Results leave on the rsp_ channel with a
// status in tuser; tlast marks the last pixel of an output row, which also
// carries the row's pad byte count. A pixel offered during replay is refused,
// and a tick during loading answers that nothing is ready; a stored pixel
// gives no result. Settings are written on the csr_ channel, which is always
// ready and should only be used while the block is idle.
// Results are registered in the back end, and one item is accepted every cycle
// while the queue has room; that rate is set by the single line store
// port used per cycle in the back end. A front register and a four-item queue
// sit between the channels, so items are still taken while a result waits on
// a stalled receiver, until the queue is full. Reset clears all counters and
// restores every setting to one; the line store is not cleared.
// ----------------------------------------------------------------------------
module pixel_replicating_upscaler (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,  // red_in, green_in, blue_in
   input  logic [0:0]                        req_tuser,  // mode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,  // red_out, green_out, blue_out, pad_bytes
   output logic [2:0]                        rsp_tuser,  // status, image_end
   output logic                              rsp_tlast,  // row_end
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [upscl_pkg::CsrIdxBits-1:0]  csr_index,
   input  logic [upscl_pkg::CsrDataBits-1:0] csr_data
);
   import upscl_pkg::*;

   logic           push_valid;
   logic           push_ready;
   item_type       push_item;
   queue_head_type head;
   logic           pop;

   upscl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   upscl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .head       (head),
      .pop        (pop)
   );

   upscl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== sim/pixel_replicating_upscaler_tb.sv =====
// ----------------------------------------------------------------------------
// Pixel-replicating upscaler testbench
// Drives source pixels and emit ticks into the upscaler under random flow
// control on both channels. The settings are reprogrammed between phases,
// with out-of-range and extreme values among them. A scoreboard predicts
// every result from its own copy of the line store and counters, and checks
// each returned item field by field.
// ----------------------------------------------------------------------------
module pixel_replicating_upscaler_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import upscl_pkg::*;

   localparam int IdleLimit  = 4000;
   localparam int DrainPause = 12;
   localparam int PhaseItems = 110;
   localparam int PhaseCount = 19;

   typedef struct packed {
      status_type  status;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [1:0]  pad;
      logic        row_end;
      logic        image_end;
   } out_pixel_type;

   class upscale_scoreboard;
      logic [6:0]    scale_reg;
      logic [10:0]   width_reg;
      logic [12:0]   height_reg;
      logic [23:0]   line_store [MaxWidth];
      int            load_col;
      int            out_col;
      int            copy_cnt;
      int            row_rep;
      int            src_row;
      bit            replaying;
      int            hi_written;
      int            errors;
      out_pixel_type due_results [$];

      function new();
         scale_reg  = 7'd1;
         width_reg  = 11'd1;
         height_reg = 13'd1;
         load_col   = 0;
         out_col    = 0;
         copy_cnt   = 0;
         row_rep    = 0;
         src_row    = 0;
         replaying  = 1'b0;
         hi_written = 0;
         errors     = 0;
      endfunction

      function int clamp_width(logic [10:0] v);
         if (v == 0) return 1;
         return (v > MaxWidth) ? MaxWidth : int'(v);
      endfunction

      function int eff_scale();
         if (scale_reg == 0) return 1;
         return (scale_reg > ScaleLimit) ? ScaleLimit : int'(scale_reg);
      endfunction

      function int eff_height();
         if (height_reg == 0) return 1;
         return (height_reg > HeightLimit) ? HeightLimit : int'(height_reg);
      endfunction

      function void set_reg(csr_index_type idx, logic [12:0] v);
         case (idx)
            CSR_SCALE:  scale_reg  = v[6:0];
            CSR_WIDTH:  width_reg  = v[10:0];
            CSR_HEIGHT: height_reg = v;
            default: ;
         endcase
      endfunction

      function void take_item(kind_type kind, logic [23:0] rgb);
         int            s;
         int            w;
         int            h;
         bit            col_last;
         bit            copy_last;
         bit            rep_last;
         logic [23:0]   px;
         out_pixel_type r;
         s = eff_scale();
         w = clamp_width(width_reg);
         h = eff_height();
         r = '0;
         if (kind == KIND_PIXEL) begin
            if (replaying) begin
               r.status = ST_REFUSED;
               due_results.push_back(r);
               return;
            end
            line_store[load_col] = rgb;
            if (load_col + 1 > hi_written) hi_written = load_col + 1;
            if (load_col + 1 >= w) begin
               load_col  = 0;
               replaying = 1'b1;
               out_col   = 0;
               copy_cnt  = 0;
               row_rep   = 0;
            end else begin
               load_col++;
            end
            return;
         end
         if (!replaying) begin
            r.status = ST_IDLE;
            due_results.push_back(r);
            return;
         end
         px        = line_store[out_col];
         col_last  = (out_col + 1 >= w);
         copy_last = (copy_cnt + 1 >= s);
         rep_last  = (row_rep + 1 >= s);
         r.status    = ST_PIXEL;
         r.red       = px[23:16];
         r.green     = px[15:8];
         r.blue      = px[7:0];
         r.row_end   = col_last && copy_last;
         r.image_end = r.row_end && rep_last && (src_row + 1 >= h);
         r.pad       = r.row_end ? 2'((4 - (w * s * 3) % 4) % 4) : 2'd0;
         due_results.push_back(r);
         if (!copy_last) begin
            copy_cnt++;
         end else begin
            copy_cnt = 0;
            if (!col_last) begin
               out_col++;
            end else begin
               out_col = 0;
               if (!rep_last) begin
                  row_rep++;
               end else begin
                  row_rep   = 0;
                  replaying = 1'b0;
                  load_col  = 0;
                  src_row   = (src_row + 1 >= h) ? 0 : src_row + 1;
               end
            end
         end
      endfunction

      function void check_result(out_pixel_type got);
         out_pixel_type exp;
         if (due_results.size() == 0) begin
            $error("unexpected result item, status %0d", got.status);
            errors++;
            return;
         end
         exp = due_results.pop_front();
         if (got.status != exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            errors++;
         end
         if (got.red != exp.red) begin
            $error("red_out: expected %0d, got %0d", exp.red, got.red);
            errors++;
         end
         if (got.green != exp.green) begin
            $error("green_out: expected %0d, got %0d", exp.green, got.green);
            errors++;
         end
         if (got.blue != exp.blue) begin
            $error("blue_out: expected %0d, got %0d", exp.blue, got.blue);
            errors++;
         end
         if (got.pad != exp.pad) begin
            $error("pad_bytes: expected %0d, got %0d", exp.pad, got.pad);
            errors++;
         end
         if (got.row_end != exp.row_end) begin
            $error("row_end: expected %0d, got %0d", exp.row_end, got.row_end);
            errors++;
         end
         if (got.image_end != exp.image_end) begin
            $error("image_end: expected %0d, got %0d", exp.image_end, got.image_end);
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [23:0]            req_tdata;  // red_in, green_in, blue_in
   logic [0:0]             req_tuser;  // mode
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [31:0]            rsp_tdata;  // red_out, green_out, blue_out, pad_bytes
   logic [2:0]             rsp_tuser;  // status, image_end
   logic                   rsp_tlast;  // row_end
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CsrIdxBits-1:0]  csr_index;
   logic [CsrDataBits-1:0] csr_data;

   upscale_scoreboard model;
   bit                tx_eager;
   bit                rx_eager;

   pixel_replicating_upscaler u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap(bit eager);
      int r;
      if (eager) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_item(kind_type kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {b, g, r};
      do begin
         @(posedge clock);
      end while (!req_tready);
      model.take_item(kind, {r, g, b});
      @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [12:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      model.set_reg(idx, v);
      @(negedge clock);
   endtask

   task automatic program_regs(logic [12:0] s, logic [12:0] w, logic [12:0] h);
      // A wider row during replay would read store slots never loaded.
      if (model.replaying && model.clamp_width(w[10:0]) > model.hi_written) begin
         w = 13'(model.hi_written);
      end
      write_reg(CSR_SCALE, s);
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (model.due_results.size() != 0) @(negedge clock);
      repeat (DrainPause) @(negedge clock);
   endtask

   task automatic run_phase(int count);
      kind_type kind;
      bit       well;
      int       gap;
      for (int n = 0; n < count; n++) begin
         well = ($urandom_range(0, 99) < 85);
         kind = kind_type'(model.replaying ~^ well);
         send_item(kind, 8'($urandom), 8'($urandom), 8'($urandom));
         gap = pick_gap(tx_eager);
         if (gap > 0 || n == count - 1) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   always begin
      @(posedge clock);
      if (rsp_tvalid && rsp_tready) begin
         model.check_result('{status:    status_type'(rsp_tuser[1:0]),
                              red:       rsp_tdata[7:0],
                              green:     rsp_tdata[15:8],
                              blue:      rsp_tdata[23:16],
                              pad:       rsp_tdata[25:24],
                              row_end:   rsp_tlast,
                              image_end: rsp_tuser[2]});
      end
   end

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap(rx_eager);
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IdleLimit) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("[pixel_replicating_upscaler] ERROR");
      $finish;
   end

   initial begin
      logic [12:0] fixed_cfg [5][3];
      logic [12:0] s;
      logic [12:0] w;
      logic [12:0] h;
      fixed_cfg = '{'{13'd8191, 13'd8191, 13'd8191},
                    '{13'd1,    13'd1024, 13'd4096},
                    '{13'd100,  13'd1,    13'd1},
                    '{13'd0,    13'd0,    13'd0},
                    '{13'd3,    13'd5,    13'd2}};
      model      = new();
      tx_eager   = 1'b1;
      rx_eager   = 1'b1;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_SCALE;
      csr_data   = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // After reset every setting is one, so each pixel is a whole image.
      send_item(KIND_TICK,  8'h00, 8'h00, 8'h00);
      send_item(KIND_PIXEL, 8'hff, 8'hff, 8'hff);
      send_item(KIND_PIXEL, 8'h00, 8'h00, 8'h00);
      send_item(KIND_TICK,  8'hff, 8'hff, 8'hff);
      send_item(KIND_PIXEL, 8'h00, 8'h00, 8'h00);
      send_item(KIND_TICK,  8'h00, 8'h00, 8'h00);
      send_item(KIND_TICK,  8'h00, 8'h00, 8'h00);
      send_item(KIND_PIXEL, 8'ha5, 8'h5a, 8'hc3);
      send_item(KIND_TICK,  8'h3c, 8'hc3, 8'h5a);
      req_tvalid <= 1'b0;
      drain();

      for (int p = 0; p < PhaseCount; p++) begin
         if (p < 5) begin
            s = fixed_cfg[p][0];
            w = fixed_cfg[p][1];
            h = fixed_cfg[p][2];
         end else begin
            s = ($urandom_range(0, 99) < 80) ? 13'($urandom_range(1, 3))
                                             : 13'($urandom_range(0, 127));
            w = ($urandom_range(0, 99) < 80) ? 13'($urandom_range(1, 6))
                                             : 13'($urandom_range(0, 2047));
            h = ($urandom_range(0, 99) < 80) ? 13'($urandom_range(1, 3))
                                             : 13'($urandom_range(0, 8191));
         end
         program_regs(s, w, h);
         tx_eager = ($urandom_range(0, 3) == 0);
         rx_eager = ($urandom_range(0, 3) == 0);
         run_phase(PhaseItems);
         drain();
      end

      if (model.errors == 0) begin
         $display("[pixel_replicating_upscaler] OK");
      end else begin
         $display("[pixel_replicating_upscaler] ERROR");
      end
      $finish;
   end

endmodule
